// ----- hdl/lps_pkg.sv -----
// led pattern sequencer package: command codes, mode encoding, request and result types
// no dependencies
package lps_pkg;

  localparam logic [7:0] CmdClear  = 8'h17;
  localparam logic [7:0] CmdStatic = 8'h80;
  localparam logic [7:0] CmdBinary = 8'h40;
  localparam logic [7:0] CmdRotate = 8'h20;
  localparam logic [7:0] CmdPair   = 8'h10;

  localparam logic [7:0] StaticPattern = 8'h55;
  localparam logic [7:0] BinaryLast    = 8'd254;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_BINARY = 2'd1,
    MODE_ROTATE = 2'd2,
    MODE_PAIR   = 2'd3
  } mode_e;

  typedef struct packed {
    logic       tick;
    logic [7:0] cmd_byte;
  } req_t;

  typedef struct packed {
    logic       alert;
    logic [7:0] leds;
  } result_t;

  function automatic logic [7:0] pair_pattern(input logic [2:0] idx);
    logic [7:0] pat;
    case (idx)
      3'd0:    pat = 8'h00;
      3'd1:    pat = 8'h18;
      3'd2:    pat = 8'h24;
      3'd3:    pat = 8'h42;
      3'd4:    pat = 8'h81;
      3'd5:    pat = 8'h42;
      3'd6:    pat = 8'h24;
      3'd7:    pat = 8'h18;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

// ----- hdl/lps_engine.sv -----
// led pattern sequencer engine: mode, counters and led state with their update logic
// depends on lps_pkg
module lps_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  lps_pkg::req_t    req_i,
  output lps_pkg::result_t result_o
);

  lps_pkg::mode_e mode_q, mode_d;
  logic [7:0] bin_cnt_q, bin_cnt_d;
  logic [2:0] rot_cnt_q, rot_cnt_d;
  logic [2:0] pair_cnt_q, pair_cnt_d;
  logic [7:0] leds_q, leds_d;
  logic       alert_q, alert_d;

  always_comb begin
    mode_d     = mode_q;
    bin_cnt_d  = bin_cnt_q;
    rot_cnt_d  = rot_cnt_q;
    pair_cnt_d = pair_cnt_q;
    leds_d     = leds_q;
    alert_d    = alert_q;
    if (req_i.tick) begin
      case (mode_q)
        lps_pkg::MODE_BINARY: begin
          leds_d    = bin_cnt_q;
          bin_cnt_d = (bin_cnt_q >= lps_pkg::BinaryLast) ? 8'd0 : bin_cnt_q + 8'd1;
        end
        lps_pkg::MODE_ROTATE: begin
          leds_d    = 8'd1 << rot_cnt_q;
          rot_cnt_d = rot_cnt_q + 3'd1;
        end
        lps_pkg::MODE_PAIR: begin
          leds_d     = lps_pkg::pair_pattern(pair_cnt_q);
          pair_cnt_d = pair_cnt_q + 3'd1;
        end
        default: ;
      endcase
    end else begin
      case (req_i.cmd_byte)
        lps_pkg::CmdClear: begin
          alert_d    = 1'b0;
          mode_d     = lps_pkg::MODE_NONE;
          bin_cnt_d  = 8'd0;
          rot_cnt_d  = 3'd0;
          pair_cnt_d = 3'd0;
          leds_d     = 8'd0;
        end
        lps_pkg::CmdStatic: begin
          alert_d = 1'b1;
          mode_d  = lps_pkg::MODE_NONE;
          leds_d  = lps_pkg::StaticPattern;
        end
        lps_pkg::CmdBinary: begin
          alert_d = 1'b1;
          mode_d  = lps_pkg::MODE_BINARY;
        end
        lps_pkg::CmdRotate: begin
          alert_d = 1'b1;
          mode_d  = lps_pkg::MODE_ROTATE;
        end
        lps_pkg::CmdPair: begin
          alert_d = 1'b1;
          mode_d  = lps_pkg::MODE_PAIR;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= lps_pkg::MODE_NONE;
      bin_cnt_q  <= 8'd0;
      rot_cnt_q  <= 3'd0;
      pair_cnt_q <= 3'd0;
      leds_q     <= 8'd0;
      alert_q    <= 1'b0;
    end else if (advance_i) begin
      mode_q     <= mode_d;
      bin_cnt_q  <= bin_cnt_d;
      rot_cnt_q  <= rot_cnt_d;
      pair_cnt_q <= pair_cnt_d;
      leds_q     <= leds_d;
      alert_q    <= alert_d;
    end
  end

  assign result_o.leds  = leds_d;
  assign result_o.alert = alert_d;

endmodule

// ----- hdl/lps_out_reg.sv -----
// led pattern sequencer result register with valid/ready handshake
// depends on lps_pkg
module lps_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  lps_pkg::result_t result_i,
  input  logic             ready_i,
  output logic             valid_o,
  output logic             free_o,
  output lps_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  lps_pkg::result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- hdl/led_pattern_sequencer_core.sv -----
// led pattern sequencer top level: input register, engine and result register
// depends on lps_pkg, lps_engine and lps_out_reg
//
// Usage: each request on the slave stream is either a command byte (tuser = 0,
// byte in tdata) or an animation timer tick (tuser = 1, tdata ignored). Every
// request yields exactly one result on the master stream, holding the eight
// LED states and the alert LED after that request.
// Path: a request accepted on the slave side is captured in the input register,
// processed by the engine once the result register is free, and loaded into
// the result register, which drives the master side and raises tvalid.
// Throughput: one request per cycle while m_axis_tready stays high, set by the
// state update in the engine; the input register and the result register keep
// both sides moving together.
// Stall: while a result waits for tready the result register holds it; one
// more request may sit in the input register, after which s_axis_tready drops
// until the master side takes the waiting result.
// Reset: rst_ni clears both valid flags, the mode, all counters and all LEDs,
// so the block starts with every LED off and no animation selected.
module led_pattern_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] cmd_byte
  input  logic        s_axis_tuser,  // [0] cmd (1 = tick)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [7:0] leds, [8] alert, [15:9] zero
);

  logic             in_valid_q, in_valid_d;
  lps_pkg::req_t    req_q;
  logic             advance;
  logic             out_free;
  lps_pkg::result_t next_res;
  lps_pkg::result_t out_res;

  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_valid_d    = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q.tick     <= s_axis_tuser;
      req_q.cmd_byte <= s_axis_tdata;
    end
  end

  lps_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (req_q),
    .result_o  (next_res)
  );

  lps_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (next_res),
    .ready_i  (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .free_o   (out_free),
    .result_o (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res.alert, out_res.leds};

endmodule
